FILE: rtl/msg_pkg.sv
// Shared constants, codes and types of the momentum signal generator.
`timescale 1ns / 1ps

package msg_pkg;

   localparam int SYMBOLS        = 256;
   localparam int ADDR_BITS      = $clog2(SYMBOLS);
   localparam int SYM_BITS       = 8;
   localparam int PRICE_BITS     = 32;
   localparam int MID_BITS       = PRICE_BITS + 1;
   localparam int THR_BITS       = 24;
   localparam int FRAC_BITS      = 24;
   localparam int PROD_BITS      = MID_BITS + FRAC_BITS;
   localparam int TIME_BITS      = 32;
   localparam int TAG_BITS       = 32;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [THR_BITS-1:0]  THRESHOLD_RESET    = THR_BITS'(16777);
   localparam logic [TIME_BITS-1:0] MIN_INTERVAL_RESET = TIME_BITS'(100);
   localparam logic [TAG_BITS-1:0]  STRATEGY_TAG_RESET = TAG_BITS'(1001);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_THRESHOLD    = 2'd0,
      CSR_MIN_INTERVAL = 2'd1,
      CSR_STRATEGY_TAG = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [THR_BITS-1:0]  threshold;
      logic [TIME_BITS-1:0] min_interval;
      logic [TAG_BITS-1:0]  strategy_tag;
   } cfg_type;

   typedef struct packed {
      logic emit;
      logic direction;
   } decision_type;

endpackage

FILE: rtl/momentum_signal_generator_core.sv
// Top level: quote register, per-symbol state, decision and signal output register.
//
//  channel | direction | handshake               | payload
//  req_    | in        | req_valid / req_stall   | symbol_id, bid_ticks, ask_ticks, now_ms
//  rsp_    | out       | rsp_valid / rsp_stall   | signal_symbol, direction, signal_tag
//  csr_    | in        | csr_write_en            | csr_index, csr_wdata
//
// One quote a cycle is accepted while req_stall is low. Each quote is registered in the quote stage
// beside the registered read of the per-symbol price and time RAMs, and its signal in the rsp_ register.
// Reset clears the seen flags of all symbols at once and loads the register defaults.
// req_stall rises only while a quote is held behind a stalled signal in rsp_.
`timescale 1ns / 1ps

module momentum_signal_generator_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [msg_pkg::SYM_BITS-1:0]        req_symbol_id,
   input  logic [31:0]                         req_bid_ticks,
   input  logic [31:0]                         req_ask_ticks,
   input  logic [msg_pkg::TIME_BITS-1:0]       req_now_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [msg_pkg::SYM_BITS-1:0]        rsp_signal_symbol,
   output logic                                rsp_direction,
   output logic [msg_pkg::TAG_BITS-1:0]        rsp_signal_tag,
   input  logic                                csr_write_en,
   input  logic [msg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [msg_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   msg_pkg::cfg_type      cfg;
   msg_pkg::decision_type decision;

   logic                           accept;
   logic                           out_free;
   logic                           retire;
   logic                           emit_now;
   logic [msg_pkg::ADDR_BITS-1:0]  req_addr;
   logic [msg_pkg::MID_BITS-1:0]   req_mid;
   logic                           req_in_range;

   // quote stage
   logic                           s1_valid_ff, s1_valid_in;
   logic [msg_pkg::SYM_BITS-1:0]   s1_symbol_ff;
   logic [msg_pkg::MID_BITS-1:0]   s1_mid_ff;
   logic [msg_pkg::TIME_BITS-1:0]  s1_now_ff;
   logic                           s1_range_ff;
   logic [msg_pkg::ADDR_BITS-1:0]  s1_addr;

   // bypass of the write made at the edge the current quote was read
   logic                           byp_hit_ff, byp_hit_in;
   logic                           byp_time_hit_ff, byp_time_hit_in;
   logic [msg_pkg::MID_BITS-1:0]   byp_mid_ff;
   logic [msg_pkg::TIME_BITS-1:0]  byp_time_ff;

   logic [msg_pkg::SYMBOLS-1:0]    price_seen_ff, price_seen_in;
   logic [msg_pkg::SYMBOLS-1:0]    signal_seen_ff, signal_seen_in;

   logic [msg_pkg::MID_BITS-1:0]   ram_mid;
   logic [msg_pkg::TIME_BITS-1:0]  ram_time;
   logic [msg_pkg::MID_BITS-1:0]   old_mid;
   logic [msg_pkg::TIME_BITS-1:0]  old_time;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [msg_pkg::SYM_BITS-1:0]   rsp_symbol_ff;
   logic                           rsp_direction_ff;
   logic [msg_pkg::TAG_BITS-1:0]   rsp_tag_ff;

   msg_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign retire    = s1_valid_ff && out_free && s1_range_ff;
   assign emit_now  = retire && decision.emit;

   assign req_addr     = req_symbol_id[msg_pkg::ADDR_BITS-1:0];
   assign req_mid      = msg_pkg::MID_BITS'(req_bid_ticks[msg_pkg::PRICE_BITS-1:0])
                       + msg_pkg::MID_BITS'(req_ask_ticks[msg_pkg::PRICE_BITS-1:0]);
   assign req_in_range = 32'(req_symbol_id) < 32'(msg_pkg::SYMBOLS);
   assign s1_addr      = s1_symbol_ff[msg_pkg::ADDR_BITS-1:0];

   msg_ram #(
      .WIDTH (msg_pkg::MID_BITS),
      .DEPTH (msg_pkg::SYMBOLS)
   ) u_mid_ram (
      .clock      (clock),
      .write_en   (retire),
      .write_addr (s1_addr),
      .write_data (s1_mid_ff),
      .read_en    (accept),
      .read_addr  (req_addr),
      .read_data  (ram_mid)
   );

   msg_ram #(
      .WIDTH (msg_pkg::TIME_BITS),
      .DEPTH (msg_pkg::SYMBOLS)
   ) u_time_ram (
      .clock      (clock),
      .write_en   (emit_now),
      .write_addr (s1_addr),
      .write_data (s1_now_ff),
      .read_en    (accept),
      .read_addr  (req_addr),
      .read_data  (ram_time)
   );

   assign old_mid  = byp_hit_ff ? byp_mid_ff : ram_mid;
   assign old_time = byp_time_hit_ff ? byp_time_ff : ram_time;

   msg_decide u_decide (
      .new_mid     (s1_mid_ff),
      .old_mid     (old_mid),
      .price_seen  (price_seen_ff[s1_addr]),
      .signal_time (old_time),
      .signal_seen (signal_seen_ff[s1_addr]),
      .now_ms      (s1_now_ff),
      .cfg         (cfg),
      .decision    (decision)
   );

   always_comb begin
      s1_valid_in     = accept || (s1_valid_ff && !out_free);
      byp_hit_in      = byp_hit_ff;
      byp_time_hit_in = byp_time_hit_ff;
      if (accept) begin
         byp_hit_in      = retire && (s1_addr == req_addr);
         byp_time_hit_in = emit_now && (s1_addr == req_addr);
      end
      price_seen_in  = price_seen_ff;
      signal_seen_in = signal_seen_ff;
      if (retire) begin
         price_seen_in[s1_addr] = 1'b1;
      end
      if (emit_now) begin
         signal_seen_in[s1_addr] = 1'b1;
      end
      rsp_valid_in = out_free ? emit_now : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         byp_hit_ff      <= 1'b0;
         byp_time_hit_ff <= 1'b0;
         price_seen_ff   <= '0;
         signal_seen_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         byp_hit_ff      <= byp_hit_in;
         byp_time_hit_ff <= byp_time_hit_in;
         price_seen_ff   <= price_seen_in;
         signal_seen_ff  <= signal_seen_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers: load on accept or on emission, otherwise hold
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_symbol_ff <= req_symbol_id;
         s1_mid_ff    <= req_mid;
         s1_now_ff    <= req_now_ms;
         s1_range_ff  <= req_in_range;
         byp_mid_ff   <= s1_mid_ff;
         byp_time_ff  <= s1_now_ff;
      end
      if (emit_now) begin
         rsp_symbol_ff    <= s1_symbol_ff;
         rsp_direction_ff <= decision.direction;
         rsp_tag_ff       <= cfg.strategy_tag;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_signal_symbol = rsp_symbol_ff;
   assign rsp_direction     = rsp_direction_ff;
   assign rsp_signal_tag    = rsp_tag_ff;

endmodule

FILE: rtl/msg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module msg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_en,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[write_addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

FILE: rtl/msg_csr.sv
// Configuration register file: threshold, minimum interval and strategy tag.
`timescale 1ns / 1ps

module msg_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [msg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [msg_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output msg_pkg::cfg_type                    cfg
);

   msg_pkg::cfg_type cfg_ff;
   msg_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (msg_pkg::csr_index_type'(csr_index))
            msg_pkg::CSR_THRESHOLD: begin
               cfg_in.threshold = csr_wdata[msg_pkg::THR_BITS-1:0];
            end
            msg_pkg::CSR_MIN_INTERVAL: begin
               cfg_in.min_interval = csr_wdata[msg_pkg::TIME_BITS-1:0];
            end
            msg_pkg::CSR_STRATEGY_TAG: begin
               cfg_in.strategy_tag = csr_wdata[msg_pkg::TAG_BITS-1:0];
            end
            default: begin
               // unmapped index: drop the write
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold    <= msg_pkg::THRESHOLD_RESET;
         cfg_ff.min_interval <= msg_pkg::MIN_INTERVAL_RESET;
         cfg_ff.strategy_tag <= msg_pkg::STRATEGY_TAG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/msg_decide.sv
// Signal decision: relative move against threshold and minimum signal interval.
`timescale 1ns / 1ps

module msg_decide (
   input  logic [msg_pkg::MID_BITS-1:0]  new_mid,
   input  logic [msg_pkg::MID_BITS-1:0]  old_mid,
   input  logic                          price_seen,
   input  logic [msg_pkg::TIME_BITS-1:0] signal_time,
   input  logic                          signal_seen,
   input  logic [msg_pkg::TIME_BITS-1:0] now_ms,
   input  msg_pkg::cfg_type              cfg,
   output msg_pkg::decision_type         decision
);

   logic                           rise;
   logic [msg_pkg::MID_BITS-1:0]   move;
   logic [msg_pkg::PROD_BITS-1:0]  lhs;
   logic [msg_pkg::PROD_BITS-1:0]  rhs;
   logic [msg_pkg::TIME_BITS-1:0]  elapsed;
   logic                           time_ok;

   assign rise = new_mid > old_mid;
   assign move = rise ? (new_mid - old_mid) : (old_mid - new_mid);

   // move * 2^24 against threshold * old, both exact
   assign lhs = {move, {msg_pkg::FRAC_BITS{1'b0}}};
   assign rhs = msg_pkg::PROD_BITS'(cfg.threshold) * msg_pkg::PROD_BITS'(old_mid);

   // elapsed time wraps modulo 2^32
   assign elapsed = now_ms - signal_time;
   assign time_ok = !signal_seen || (elapsed >= cfg.min_interval);

   always_comb begin
      decision.emit = price_seen && (old_mid != '0) && (move != '0) && time_ok
                      && (lhs > rhs);
      decision.direction = !rise;
   end

endmodule

FILE: bench/tb_top.sv
// Testbench for the momentum signal generator: quote traffic, signal prediction and checking.
`timescale 1ns / 1ps

module tb_top;
   import msg_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int          DRAIN_CYCLES = 6;
   localparam int          SETTLE_LIMIT = 4000;
   localparam int          HOLD_CYCLES  = 300;
   localparam int unsigned CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic [SYM_BITS-1:0]  symbol;
      logic [31:0]          bid;
      logic [31:0]          ask;
      logic [TIME_BITS-1:0] now;
   } quote_type;

   typedef struct packed {
      logic [SYM_BITS-1:0] symbol;
      logic                direction;
      logic [TAG_BITS-1:0] tag;
   } alert_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid     = 1'b0;
   logic                      req_stall;
   logic [SYM_BITS-1:0]       req_symbol_id = '0;
   logic [31:0]               req_bid_ticks = '0;
   logic [31:0]               req_ask_ticks = '0;
   logic [TIME_BITS-1:0]      req_now_ms    = '0;
   logic                      rsp_valid;
   logic                      rsp_stall     = 1'b0;
   logic [SYM_BITS-1:0]       rsp_signal_symbol;
   logic                      rsp_direction;
   logic [TAG_BITS-1:0]       rsp_signal_tag;
   logic                      csr_write_en  = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index     = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata     = '0;

   momentum_signal_generator_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_symbol_id     (req_symbol_id),
      .req_bid_ticks     (req_bid_ticks),
      .req_ask_ticks     (req_ask_ticks),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_signal_symbol (rsp_signal_symbol),
      .rsp_direction     (rsp_direction),
      .rsp_signal_tag    (rsp_signal_tag),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Momentum model state, one entry per symbol
   cfg_type              model_cfg;
   logic [MID_BITS-1:0]  mid_book        [SYMBOLS];
   logic                 price_known     [SYMBOLS];
   logic [TIME_BITS-1:0] last_alert_time [SYMBOLS];
   logic                 alert_known     [SYMBOLS];

   quote_type   quote_backlog[$];
   alert_type   awaited_alerts[$];
   logic [31:0] walk_px [SYMBOLS];
   logic [31:0] stamp;

   int          error_count = 0;
   int unsigned cycle_count = 0;
   logic        hold_kick   = 1'b0;

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("tb_top: mismatch, %s: expected %0h, got %0h (cycle %0d)",
               what, want, got, cycle_count);
      error_count++;
   endtask

   // Decide whether a quote raises a signal and update the per-symbol state.
   function automatic decision_type judge_quote(input logic [SYM_BITS-1:0] sym,
                                               input logic [31:0] bid,
                                               input logic [31:0] ask,
                                               input logic [TIME_BITS-1:0] now);
      decision_type         verdict;
      logic [MID_BITS-1:0]  mid2;
      logic [MID_BITS-1:0]  prior;
      logic [MID_BITS-1:0]  swing;
      logic [TIME_BITS-1:0] elapsed;
      logic [63:0]          scaled_swing;
      logic [63:0]          limit;
      logic                 rising;
      logic                 time_ok;
      verdict = '0;
      mid2 = {1'b0, bid} + {1'b0, ask};
      if (price_known[sym] && mid_book[sym] != '0) begin
         prior   = mid_book[sym];
         rising  = mid2 > prior;
         swing   = rising ? mid2 - prior : prior - mid2;
         elapsed = now - last_alert_time[sym];
         time_ok = !alert_known[sym] || elapsed >= model_cfg.min_interval;
         scaled_swing = 64'(swing) << FRAC_BITS;
         limit        = 64'(model_cfg.threshold) * 64'(prior);
         if (time_ok && swing != '0 && scaled_swing > limit) begin
            verdict.emit      = 1'b1;
            verdict.direction = !rising;
            last_alert_time[sym] = now;
            alert_known[sym]     = 1'b1;
         end
      end
      mid_book[sym]    = mid2;
      price_known[sym] = 1'b1;
      return verdict;
   endfunction

   task automatic add_quote(input logic [SYM_BITS-1:0] sym, input logic [31:0] bid,
                            input logic [31:0] ask, input logic [TIME_BITS-1:0] now);
      quote_type q;
      q.symbol = sym;
      q.bid    = bid;
      q.ask    = ask;
      q.now    = now;
      quote_backlog = {quote_backlog, q};
   endtask

   // Mostly price walks on a cluster of symbols; some noise, zero and unchanged quotes.
   task automatic queue_random_quotes(input int count);
      logic [SYM_BITS-1:0] home;
      logic [SYM_BITS-1:0] sym;
      logic [31:0]         bid;
      logic [31:0]         ask;
      logic [31:0]         delta;
      int                  kind;
      int unsigned         reach;
      home  = SYM_BITS'($urandom_range(0, 255));
      reach = (model_cfg.min_interval > 300) ? 300 : model_cfg.min_interval + 1;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(0, 19);
         sym  = ($urandom_range(0, 9) == 0) ? SYM_BITS'($urandom)
                                            : home + SYM_BITS'($urandom_range(0, 7));
         if (kind < 2) begin
            bid = $urandom;
            ask = $urandom;
         end else if (kind == 2) begin
            bid = '0;
            ask = '0;
         end else if (kind == 3) begin
            bid = walk_px[sym];
            ask = bid;
         end else begin
            delta = (walk_px[sym] >> $urandom_range(3, 20)) + $urandom_range(0, 3);
            bid   = $urandom_range(0, 1) ? walk_px[sym] + delta : walk_px[sym] - delta;
            ask   = bid + $urandom_range(0, 15);
         end
         walk_px[sym] = bid;
         case ($urandom_range(0, 9))
            0:       stamp = $urandom;
            1, 2:    ;
            default: stamp = stamp + $urandom_range(0, 3 * reach);
         endcase
         add_quote(sym, bid, ask, stamp);
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      case (idx)
         CSR_THRESHOLD:    model_cfg.threshold    = value[THR_BITS-1:0];
         CSR_MIN_INTERVAL: model_cfg.min_interval = value[TIME_BITS-1:0];
         CSR_STRATEGY_TAG: model_cfg.strategy_tag = value[TAG_BITS-1:0];
         default:          ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Wait until every quote is in and every signal out, then let the pipe drain.
   task automatic settle();
      alert_type leftover;
      int        waited;
      waited = 0;
      do @(negedge clock); while (quote_backlog.size() != 0 || req_valid);
      while (awaited_alerts.size() != 0 && waited < SETTLE_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      while (awaited_alerts.size() != 0) begin
         leftover = awaited_alerts.pop_front();
         report_mismatch("signal missing for symbol", leftover.symbol, '0);
      end
   endtask

   // Sender: bursts of random length separated by random gaps
   quote_type next_quote;
   int        burst_left = 0;
   int        gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (gap_left != 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (quote_backlog.size() != 0) begin
            next_quote     = quote_backlog.pop_front();
            req_valid     <= 1'b1;
            req_symbol_id <= next_quote.symbol;
            req_bid_ticks <= next_quote.bid;
            req_ask_ticks <= next_quote.ask;
            req_now_ms    <= next_quote.now;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall modes of random length, plus a long hold on request
   int          hold_left  = 0;
   int          stall_mode = 0;
   int          mode_left  = 0;
   logic [2:0]  beat       = '0;

   always @(posedge clock) begin
      beat <= beat + 1'b1;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         mode_left <= 0;
      end else if (hold_kick) begin
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 2) == 0);
            2:       rsp_stall <= (beat < 3'd3);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Monitor: predict on each accepted quote, check each accepted signal
   decision_type verdict;
   alert_type    fresh;
   alert_type    oldest;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            verdict = judge_quote(req_symbol_id, req_bid_ticks, req_ask_ticks, req_now_ms);
            if (verdict.emit) begin
               fresh.symbol    = req_symbol_id;
               fresh.direction = verdict.direction;
               fresh.tag       = model_cfg.strategy_tag;
               awaited_alerts  = {awaited_alerts, fresh};
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_alerts.size() == 0) begin
               report_mismatch("unexpected signal for symbol", '0, rsp_signal_symbol);
            end else begin
               oldest = awaited_alerts.pop_front();
               if (rsp_signal_symbol !== oldest.symbol)
                  report_mismatch("signal_symbol", oldest.symbol, rsp_signal_symbol);
               if (rsp_direction !== oldest.direction)
                  report_mismatch("direction", oldest.direction, rsp_direction);
               if (rsp_signal_tag !== oldest.tag)
                  report_mismatch("signal_tag", oldest.tag, rsp_signal_tag);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin
      model_cfg.threshold    = THRESHOLD_RESET;
      model_cfg.min_interval = MIN_INTERVAL_RESET;
      model_cfg.strategy_tag = STRATEGY_TAG_RESET;
      foreach (price_known[i]) begin
         price_known[i]     = 1'b0;
         alert_known[i]     = 1'b0;
         mid_book[i]        = '0;
         last_alert_time[i] = '0;
         walk_px[i]         = $urandom >> $urandom_range(0, 24);
      end
      stamp = $urandom;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Register defaults: buy then a sell held back by the interval, then released
      add_quote(8'd0, 32'd1000, 32'd1000, 32'd0);
      add_quote(8'd0, 32'd1100, 32'd1100, 32'd10);
      add_quote(8'd0, 32'd500, 32'd500, 32'd50);
      add_quote(8'd0, 32'd400, 32'd400, 32'd150);
      // Widest prices, a fall to zero, then a quote after a stored zero
      add_quote(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_quote(8'd255, 32'd0, 32'd0, 32'd0);
      add_quote(8'd255, 32'd5, 32'd5, 32'd200);
      add_quote(8'd255, 32'hFFFF_FFFF, 32'd0, 32'd300);
      // Same doubled mid from swapped bid and ask: no move
      add_quote(8'd1, 32'd0, 32'hFFFF_FFFF, 32'd0);
      add_quote(8'd1, 32'hFFFF_FFFF, 32'd0, 32'd1000);
      // Interval measured across the wrap of the millisecond clock
      add_quote(8'd2, 32'd100, 32'd100, 32'hFFFF_FFF0);
      add_quote(8'd2, 32'd200, 32'd200, 32'hFFFF_FFFF);
      add_quote(8'd2, 32'd100, 32'd100, 32'h0000_0063);
      add_quote(8'd2, 32'd50, 32'd50, 32'h0000_0064);
      // Move exactly at the threshold, then one tick over it
      add_quote(8'd3, 32'h0080_0000, 32'h0080_0000, 32'd0);
      add_quote(8'd3, 32'h0080_0000, 32'h0080_0000 + 32'd16777, 32'd5);
      add_quote(8'd4, 32'h0080_0000, 32'h0080_0000, 32'd0);
      add_quote(8'd4, 32'h0080_0000, 32'h0080_0000 + 32'd16778, 32'd5);
      settle();

      // Largest threshold and interval; the top data bits beyond the threshold drop
      write_reg(CSR_THRESHOLD, '1);
      write_reg(CSR_MIN_INTERVAL, '1);
      write_reg(CSR_STRATEGY_TAG, '0);
      write_reg(CSR_UNUSED, $urandom);
      @(negedge clock);
      add_quote(8'd6, 32'd1, 32'd1, 32'd0);
      add_quote(8'd6, 32'd3, 32'd3, 32'd5);
      add_quote(8'd6, 32'd100, 32'd100, 32'd4);
      add_quote(8'd6, 32'd1000, 32'd1000, 32'd10);
      queue_random_quotes(90);
      settle();

      // Zero threshold and interval: nearly every move signals; hold the output long
      write_reg(CSR_THRESHOLD, '0);
      write_reg(CSR_MIN_INTERVAL, '0);
      write_reg(CSR_STRATEGY_TAG, '1);
      @(negedge clock);
      add_quote(8'd5, 32'd77, 32'd77, 32'd0);
      add_quote(8'd5, 32'd77, 32'd77, 32'd1);
      queue_random_quotes(120);
      @(posedge clock);
      hold_kick <= 1'b1;
      @(posedge clock);
      hold_kick <= 1'b0;
      settle();

      write_reg(CSR_THRESHOLD, $urandom_range(1000, 200000));
      write_reg(CSR_MIN_INTERVAL, $urandom_range(1, 150));
      write_reg(CSR_STRATEGY_TAG, $urandom);
      @(negedge clock);
      queue_random_quotes(130);
      settle();

      write_reg(CSR_THRESHOLD, 32'd1);
      write_reg(CSR_MIN_INTERVAL, 32'd50);
      write_reg(CSR_STRATEGY_TAG, $urandom);
      write_reg(CSR_UNUSED, '1);
      @(negedge clock);
      queue_random_quotes(100);
      settle();

      // Back to the defaults
      write_reg(CSR_THRESHOLD, 32'(THRESHOLD_RESET));
      write_reg(CSR_MIN_INTERVAL, MIN_INTERVAL_RESET);
      write_reg(CSR_STRATEGY_TAG, STRATEGY_TAG_RESET);
      @(negedge clock);
      queue_random_quotes(110);
      settle();

      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/msg_pkg.sv
rtl/msg_ram.sv
rtl/msg_csr.sv
rtl/msg_decide.sv
rtl/momentum_signal_generator_core.sv
bench/tb_top.sv
